FILE: rtl/json_string_unescaper_top_defines.svh
// ----------------------------------------------------------------------------
// json string unescaper assertion macros
// concurrent assertion wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPER_TOP_DEFINES_SVH
`define JSON_STRING_UNESCAPER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define JSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define JSU_ASSERT_NOW(lbl, ante, cons, msg)
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// types, codes and helpers shared by the json string unescaper
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  // escape decoding phase
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ESC  = 3'd1,
    PH_HEX0 = 3'd2,
    PH_HEX1 = 3'd3,
    PH_HEX2 = 3'd4,
    PH_HEX3 = 3'd5
  } phase_e;

  // end-of-string status
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ILSEQ = 2'd1,
    ST_OVFL  = 2'd2
  } status_e;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  // per-string decoder state
  typedef struct packed {
    phase_e       phase;
    logic [11:0]  accum;
    logic [15:0]  bw;
    status_e      err;
  } state_t;

  // decoded results of one input transaction
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic [1:0]      nres;
    logic            eos;
    status_e         status;
    logic [15:0]     base;
  } res_t;

  // hex digit value, bit 4 set when not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      v = 5'(c[2:0]) + 5'd9;
    else v = 5'h10;
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/jsu_in_if.sv
// ----------------------------------------------------------------------------
// jsu_in_if
// raw escaped byte channel
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/jsu_out_if.sv
// ----------------------------------------------------------------------------
// jsu_out_if
// decoded byte and status channel
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        end_of_string;
  logic [1:0]  status;
  logic [15:0] written_count;
  logic        run_last;

  modport source (output valid, output out_byte, output byte_valid,
                  output end_of_string, output status, output written_count,
                  output run_last, input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input end_of_string, input status, input written_count,
                  input run_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// one-byte step of the unescaper: next state and decoded bytes
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_decode (
  input  jsu_pkg::state_t  state_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  input  logic [15:0]      cap_i,
  output jsu_pkg::state_t  state_o,
  output jsu_pkg::res_t    res_o,
  output logic             emit_o
);
  import jsu_pkg::*;

  logic [15:0]     room;
  logic [4:0]      hex;
  logic [15:0]     cp;
  logic [1:0]      n;
  logic [2:0][7:0] buf_b;
  state_t          nxt;

  assign hex  = hex_value(byte_i);
  assign room = (state_i.bw < cap_i) ? (cap_i - state_i.bw) : 16'd0;
  assign cp   = {state_i.accum, hex[3:0]};

  // escape and token decoding
  always_comb begin
    nxt   = state_i;
    n     = 2'd0;
    buf_b = '0;
    if (state_i.err == ST_OK) begin
      unique case (state_i.phase)
        PH_ESC: begin
          nxt.phase = PH_IDLE;
          unique case (byte_i)
            CH_QUOTE, CH_BSL, CH_SLASH: begin buf_b[0] = byte_i; n = 2'd1; end
            CH_B: begin buf_b[0] = 8'h08; n = 2'd1; end
            CH_F: begin buf_b[0] = 8'h0C; n = 2'd1; end
            CH_N: begin buf_b[0] = 8'h0A; n = 2'd1; end
            CH_R: begin buf_b[0] = 8'h0D; n = 2'd1; end
            CH_T: begin buf_b[0] = 8'h09; n = 2'd1; end
            CH_U: begin
              nxt.phase = PH_HEX0;
              nxt.accum = '0;
            end
            default: nxt.err = ST_ILSEQ;
          endcase
        end
        PH_HEX0, PH_HEX1, PH_HEX2: begin
          if (hex[4]) begin
            nxt.err   = ST_ILSEQ;
            nxt.phase = PH_IDLE;
          end else begin
            nxt.accum = {state_i.accum[7:0], hex[3:0]};
            nxt.phase = phase_e'(state_i.phase + 3'd1);
          end
        end
        PH_HEX3: begin
          nxt.phase = PH_IDLE;
          nxt.accum = '0;
          if (hex[4]) begin
            nxt.err = ST_ILSEQ;
          end else if (cp < 16'h0080) begin
            buf_b[0] = cp[7:0];
            n        = 2'd1;
          end else if (cp < 16'h0800) begin
            buf_b[0] = 8'hC0 | {3'b000, cp[10:6]};
            buf_b[1] = 8'h80 | {2'b00, cp[5:0]};
            n        = 2'd2;
          end else begin
            buf_b[0] = 8'hE0 | {4'h0, cp[15:12]};
            buf_b[1] = 8'h80 | {2'b00, cp[11:6]};
            buf_b[2] = 8'h80 | {2'b00, cp[5:0]};
            n        = 2'd3;
          end
        end
        default: begin
          // idle, unused codes behave the same
          nxt.phase = PH_IDLE;
          if (room == 16'd0) nxt.err = ST_OVFL;
          else if (byte_i == CH_BSL) nxt.phase = PH_ESC;
          else begin
            buf_b[0] = byte_i;
            n        = 2'd1;
          end
        end
      endcase
      // escape output does not fit
      if ({14'd0, n} > room) begin
        n       = 2'd0;
        nxt.err = ST_OVFL;
      end
      if (last_i && nxt.err == ST_OK && nxt.phase != PH_IDLE) nxt.err = ST_ILSEQ;
    end
    nxt.bw = state_i.bw + {14'd0, n};
  end

  // result record and end-of-string clear
  always_comb begin
    res_o.bytes  = buf_b;
    res_o.nbytes = n;
    res_o.nres   = (n == 2'd0) ? 2'd1 : n;
    res_o.eos    = last_i;
    res_o.status = nxt.err;
    res_o.base   = state_i.bw;
    emit_o       = (n != 2'd0) || last_i;
    state_o      = nxt;
    if (last_i) begin
      state_o.phase = PH_IDLE;
      state_o.accum = '0;
      state_o.bw    = '0;
      state_o.err   = ST_OK;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/json_string_unescaper_top.sv
// ----------------------------------------------------------------------------
// json_string_unescaper_top
// streaming json string body unescaper with utf-8 output
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  in_i     in   valid/ready    in_byte, in_last
//  out_o    out  valid/ready    out_byte, byte_valid, end_of_string, status,
//                               written_count, run_last
//  cfg      in   cfg_we_i       cfg_wdata_i = out_capacity
//
// an input transaction is decoded in the cycle it is taken and its results
// land in a result register; they leave one per cycle while out_o is ready,
// so an input holds the input side until the last of its results is taken.
// the input is taken while the last buffered result is being taken.
// reset clears the decoder state and empties the result register; capacity
// resets to 65535. no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "json_string_unescaper_top_defines.svh"

module json_string_unescaper_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  jsu_in_if.sink      in_i,
  jsu_out_if.source   out_o
);
  import jsu_pkg::*;

  logic [15:0] cap_q;
  state_t      state_q;
  state_t      state_d;
  res_t        res_q;
  res_t        res_d;
  logic        emit;
  logic        buf_valid_q;
  logic        buf_valid_d;
  logic [1:0]  idx_q;
  logic        is_last_res;
  logic        out_take;
  logic        in_take;
  logic        has_byte;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 16'hFFFF;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  jsu_decode u_decode (
    .state_i (state_q),
    .byte_i  (in_i.in_byte),
    .last_i  (in_i.in_last),
    .cap_i   (cap_q),
    .state_o (state_d),
    .res_o   (res_d),
    .emit_o  (emit)
  );

  // handshake
  assign is_last_res = (idx_q == (res_q.nres - 2'd1));
  assign out_take    = out_o.valid && out_o.ready;
  assign in_i.ready  = !buf_valid_q || (out_take && is_last_res);
  assign in_take     = in_i.valid && in_i.ready;

  // result register occupancy, a new result wins over the drained one
  always_comb begin
    buf_valid_d = buf_valid_q;
    if (out_take && is_last_res) buf_valid_d = 1'b0;
    if (in_take && emit) buf_valid_d = 1'b1;
  end

  // decoder state and result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{phase: PH_IDLE, accum: '0, bw: '0, err: ST_OK};
      buf_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      buf_valid_q <= buf_valid_d;
      if (in_take && emit) begin
        idx_q <= '0;
      end else if (out_take && !is_last_res) begin
        idx_q <= idx_q + 2'd1;
      end
      if (in_take) begin
        state_q <= state_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_take && emit) begin
      res_q <= res_d;
    end
  end

  // output transaction fields
  assign has_byte            = (res_q.nbytes != 2'd0);
  assign out_o.valid         = buf_valid_q;
  assign out_o.out_byte      = has_byte ? res_q.bytes[idx_q] : 8'h00;
  assign out_o.byte_valid    = has_byte;
  assign out_o.run_last      = is_last_res;
  assign out_o.end_of_string = res_q.eos && is_last_res;
  assign out_o.status        = (res_q.eos && is_last_res) ? res_q.status : ST_OK;
  assign out_o.written_count = has_byte ? (res_q.base + {14'd0, idx_q} + 16'd1)
                                        : res_q.base;

  // checks
  `JSU_ASSERT_NOW(a_eos_run_last, out_o.valid && out_o.end_of_string,
                  out_o.run_last, "end of string not on last result")
  `JSU_ASSERT_NOW(a_status_eos, out_o.valid && out_o.status != ST_OK,
                  out_o.end_of_string, "error status before end of string")
  `JSU_ASSERT_NOW(a_empty_eos, out_o.valid && !out_o.byte_valid,
                  out_o.end_of_string, "empty result not at end of string")
  `JSU_ASSERT_NEXT(a_clear_last, in_take && in_i.in_last,
                   state_q.bw == 16'd0 && state_q.phase == PH_IDLE && state_q.err == ST_OK,
                   "state not cleared after last byte")

endmodule

`default_nettype wire

FILE: tb/sv/unescape_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// unescape_checker
// watches the raw byte and decoded channels of the json string unescaper,
// decodes every accepted raw byte on its own copy of the decoder state and
// compares each decoded transaction against the oldest expected one
// ----------------------------------------------------------------------------

module unescape_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  jsu_in_if           in_i,
  jsu_out_if          out_i,
  output int          fail_count_o,
  output int          pending_o
);
  import jsu_pkg::*;

  // control bytes produced by the single-letter escapes
  localparam logic [7:0] BYTE_BS = 8'h08;
  localparam logic [7:0] BYTE_FF = 8'h0C;
  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_HT = 8'h09;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        end_of_string;
    logic [1:0]  status;
    logic [15:0] written_count;
    logic        run_last;
  } decoded_t;

  decoded_t    decoded_q[$];
  logic [15:0] capacity_q;
  phase_e      phase_q;
  logic [11:0] accum_q;
  logic [15:0] written_q;
  status_e     err_q;
  int          errors;

  // value of a hex digit, 16 when the byte is not one
  function automatic int digit_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return 16;
  endfunction

  // one field compare, returns 1 on mismatch
  function automatic int check_field(input string name, input logic [15:0] exp_v,
                                     input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  // decode one raw byte and queue the decoded transactions it causes
  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic [7:0]  dec [3];
    int          n;
    int          room;
    int          d;
    logic [15:0] cp;
    logic [15:0] cnt;
    decoded_t    r;
    n = 0;
    dec[0] = '0;
    dec[1] = '0;
    dec[2] = '0;
    if (err_q == ST_OK) begin
      room = (written_q < capacity_q) ? int'(capacity_q - written_q) : 0;
      case (phase_q)
        PH_ESC: begin
          phase_q = PH_IDLE;
          case (b)
            CH_QUOTE, CH_BSL, CH_SLASH: begin dec[0] = b; n = 1; end
            CH_B: begin dec[0] = BYTE_BS; n = 1; end
            CH_F: begin dec[0] = BYTE_FF; n = 1; end
            CH_N: begin dec[0] = BYTE_LF; n = 1; end
            CH_R: begin dec[0] = BYTE_CR; n = 1; end
            CH_T: begin dec[0] = BYTE_HT; n = 1; end
            CH_U: begin
              phase_q = PH_HEX0;
              accum_q = '0;
            end
            default: err_q = ST_ILSEQ;
          endcase
        end
        PH_HEX0, PH_HEX1, PH_HEX2: begin
          d = digit_of(b);
          if (d > 15) begin
            err_q = ST_ILSEQ;
            phase_q = PH_IDLE;
          end else begin
            accum_q = {accum_q[7:0], d[3:0]};
            phase_q = phase_e'(phase_q + 3'd1);
          end
        end
        PH_HEX3: begin
          phase_q = PH_IDLE;
          d = digit_of(b);
          if (d > 15) begin
            err_q = ST_ILSEQ;
          end else begin
            cp = {accum_q, d[3:0]};
            if (cp < 16'h0080) begin
              dec[0] = cp[7:0];
              n = 1;
            end else if (cp < 16'h0800) begin
              dec[0] = {3'b110, cp[10:6]};
              dec[1] = {2'b10, cp[5:0]};
              n = 2;
            end else begin
              dec[0] = {4'b1110, cp[15:12]};
              dec[1] = {2'b10, cp[11:6]};
              dec[2] = {2'b10, cp[5:0]};
              n = 3;
            end
          end
          accum_q = '0;
        end
        default: begin
          phase_q = PH_IDLE;
          if (room == 0) err_q = ST_OVFL;
          else if (b == CH_BSL) phase_q = PH_ESC;
          else begin dec[0] = b; n = 1; end
        end
      endcase
      // an escape that does not fit writes nothing
      if (n > room) begin
        n = 0;
        err_q = ST_OVFL;
      end
      if (last && err_q == ST_OK && phase_q != PH_IDLE) err_q = ST_ILSEQ;
    end

    // one transaction per decoded byte
    cnt = written_q;
    for (int k = 0; k < n; k++) begin
      cnt++;
      r.out_byte      = dec[k];
      r.byte_valid    = 1'b1;
      r.end_of_string = last && (k == n - 1);
      r.status        = (last && (k == n - 1)) ? err_q : ST_OK;
      r.written_count = cnt;
      r.run_last      = (k == n - 1);
      decoded_q.push_back(r);
    end
    written_q = cnt;

    // end of string: status transaction if nothing was decoded, then clear
    if (last) begin
      if (n == 0) begin
        r.out_byte      = '0;
        r.byte_valid    = 1'b0;
        r.end_of_string = 1'b1;
        r.status        = err_q;
        r.written_count = written_q;
        r.run_last      = 1'b1;
        decoded_q.push_back(r);
      end
      phase_q   = PH_IDLE;
      accum_q   = '0;
      written_q = '0;
      err_q     = ST_OK;
    end
  endtask

  // monitor: config, raw bytes, then decoded transactions
  always @(posedge clk_i or negedge rst_ni) begin
    decoded_t got;
    decoded_t want;
    if (!rst_ni) begin
      decoded_q.delete();
      capacity_q   = 16'hFFFF;
      phase_q      = PH_IDLE;
      accum_q      = '0;
      written_q    = '0;
      err_q        = ST_OK;
      errors       = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) capacity_q = cfg_wdata_i;
      if (in_i.valid && in_i.ready) decode_byte(in_i.in_byte, in_i.in_last);
      if (out_i.valid && out_i.ready) begin
        got.out_byte      = out_i.out_byte;
        got.byte_valid    = out_i.byte_valid;
        got.end_of_string = out_i.end_of_string;
        got.status        = out_i.status;
        got.written_count = out_i.written_count;
        got.run_last      = out_i.run_last;
        if (decoded_q.size() == 0) begin
          $error("unexpected transaction: out_byte %0h written_count %0d",
                 got.out_byte, got.written_count);
          errors++;
        end else begin
          want = decoded_q.pop_front();
          errors += check_field("out_byte", 16'(want.out_byte), 16'(got.out_byte));
          errors += check_field("byte_valid", 16'(want.byte_valid), 16'(got.byte_valid));
          errors += check_field("end_of_string", 16'(want.end_of_string),
                                16'(got.end_of_string));
          errors += check_field("status", 16'(want.status), 16'(got.status));
          errors += check_field("written_count", want.written_count, got.written_count);
          errors += check_field("run_last", 16'(want.run_last), 16'(got.run_last));
        end
      end
      fail_count_o <= errors;
      pending_o    <= decoded_q.size();
    end
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the json string unescaper: directed escapes and
// error cases, then random strings over several capacities and idle modes
// ----------------------------------------------------------------------------

module tb;
  import jsu_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int PHASE_ITEMS   = 45;
  localparam int NUM_PHASES    = 8;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          fail_count;
  int          pending;

  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_token;
  int          items_sent;
  int unsigned cycle_cnt;
  logic [7:0]  str_q[$];

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescaper_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  unescape_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_token) begin
        hold_seen = hold_token;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ascii hex digit of either case
  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
    if (v < 4'd10) return 8'("0") + 8'(v);
    return (lower ? 8'("a") : 8'("A")) + 8'(v) - 8'd10;
  endfunction

  // letter after a backslash that forms a legal escape
  function automatic logic [7:0] escape_letter(input int idx);
    case (idx)
      0: return CH_QUOTE;
      1: return CH_BSL;
      2: return CH_SLASH;
      3: return CH_B;
      4: return CH_F;
      5: return CH_N;
      6: return CH_R;
      default: return CH_T;
    endcase
  endfunction

  // one raw byte transaction, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // send the queued string, marking its final byte when asked
  task automatic send_string(input bit with_last);
    foreach (str_q[i]) send_byte(str_q[i], with_last && (i == str_q.size() - 1));
    str_q.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) str_q.push_back(s[i]);
  endtask

  // hold the input until every expected transaction has come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] v);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // append one token, mostly well formed; returns 1 when the string must end
  task automatic add_token(output bit stop);
    logic [7:0]  v;
    logic [15:0] cp;
    int          pos;
    int          k;
    stop = 1'b0;
    case ($urandom_range(99)) inside
      [0:44]: begin
        v = 8'($urandom_range(255));
        if (v == CH_BSL) v = 8'h5B;
        str_q.push_back(v);
      end
      [45:64]: begin
        str_q.push_back(CH_BSL);
        str_q.push_back(escape_letter($urandom_range(7)));
      end
      [65:89]: begin
        case ($urandom_range(2))
          0: cp = 16'($urandom_range(16'h007F));
          1: cp = 16'($urandom_range(16'h07FF, 16'h0080));
          default: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
        endcase
        str_q.push_back(CH_BSL);
        str_q.push_back(CH_U);
        for (int i = 3; i >= 0; i--)
          str_q.push_back(hex_char(cp[i*4 +: 4], 1'($urandom_range(1))));
      end
      default: begin
        case ($urandom_range(2))
          // unknown escape letter
          0: begin
            v = 8'($urandom_range(255));
            case (v)
              CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U: v = "x";
              default: ;
            endcase
            str_q.push_back(CH_BSL);
            str_q.push_back(v);
          end
          // bad hex digit at a random position
          1: begin
            pos = $urandom_range(3);
            v = 8'($urandom_range(255));
            if ((v >= "0" && v <= "9") || (v >= "A" && v <= "F") || (v >= "a" && v <= "f"))
              v = "g";
            str_q.push_back(CH_BSL);
            str_q.push_back(CH_U);
            for (int i = 0; i < 4; i++)
              str_q.push_back((i == pos) ? v :
                              hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
          end
          // string cut off inside an escape
          default: begin
            k = $urandom_range(4);
            str_q.push_back(CH_BSL);
            if (k > 0) begin
              str_q.push_back(CH_U);
              for (int i = 1; i < k; i++)
                str_q.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
            end
            stop = 1'b1;
          end
        endcase
      end
    endcase
  endtask

  // stimulus and verdict
  initial begin
    int          ntok;
    int          target;
    bit          stop;
    logic [15:0] cap;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    in_ch.in_last = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_token     = 0;
    items_sent     = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes of the byte and every single-letter escape
    str_q.push_back(8'h00);
    str_q.push_back(8'hFF);
    push_text("\\\"\\\\\\/\\b\\f\\n\\r\\t");
    send_string(1'b1);
    // unknown escape, then a byte that is ignored
    push_text("\\xZ");
    send_string(1'b1);
    // bad hex digit
    push_text("\\uG");
    send_string(1'b1);
    // string ends inside an escape
    push_text("\\");
    send_string(1'b1);
    // capacity lowered mid-string, no room at the next token
    push_text("ab");
    send_string(1'b0);
    write_capacity(16'd1);
    push_text("c");
    send_string(1'b1);
    // two-byte escape does not fit in one byte of room
    push_text("\\u00e9");
    send_string(1'b1);
    // no room at all
    write_capacity(16'd0);
    push_text("a");
    send_string(1'b1);

    // random strings over capacities and idle modes
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: cap = 16'd0;
        1: cap = 16'd1;
        2: cap = 16'd3;
        3: cap = 16'($urandom_range(24, 2));
        4: cap = 16'd6;
        5: cap = 16'($urandom_range(16'hFFFE, 25));
        6: cap = 16'hFFFF;
        default: cap = 16'($urandom_range(12, 4));
      endcase
      write_capacity(cap);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      // receiver holds off while the sender keeps offering bytes
      if (p == 4 || p == 6) hold_token++;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        ntok = $urandom_range(8, 1);
        stop = 1'b0;
        for (int t = 0; t < ntok && !stop; t++) add_token(stop);
        send_string(1'b1);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
